// ===== sv/zdam_pkg.sv =====
// Zone dwell alarm monitor: shared types and constants.
// Configuration layout, state codes, register indexes and fixed field widths.
// No dependencies.
package zdam_pkg;

    localparam int CFG_DATA_BITS  = 22;
    localparam int CFG_INDEX_BITS = 3;
    localparam int MS_BITS        = 22;
    localparam int RADIUS_BITS    = 9;
    localparam int CENTER_BITS    = 11;
    localparam int DIST_BITS      = 25;
    localparam int STATE_BITS     = 3;
    localparam int QUEUE_DEPTH    = 4;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_DWELL_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COOLDOWN    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOSS_TOL    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SAFE_RADIUS = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y    = 3'd5;

    // monitor states
    localparam logic [STATE_BITS-1:0] ST_NORMAL    = 3'd0;
    localparam logic [STATE_BITS-1:0] ST_EXCEEDING = 3'd1;
    localparam logic [STATE_BITS-1:0] ST_ALARMED   = 3'd2;
    localparam logic [STATE_BITS-1:0] ST_COOLING   = 3'd3;
    localparam logic [STATE_BITS-1:0] ST_LOST      = 3'd4;

    localparam int unsigned GAP_LIMIT_MS = 2000;
    localparam logic [MS_BITS-1:0] DEFAULT_LOSS_MS = 22'd300;

    typedef struct packed {
        logic [MS_BITS-1:0]     dwell_limit_ms;
        logic [MS_BITS-1:0]     cooldown_ms;
        logic [MS_BITS-1:0]     loss_tolerance_ms;
        logic [RADIUS_BITS-1:0] zone_radius;
        logic [CENTER_BITS-1:0] center_x;
        logic [CENTER_BITS-1:0] center_y;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        dwell_limit_ms:    22'd1000,
        cooldown_ms:       22'd5000,
        loss_tolerance_ms: 22'd300,
        zone_radius:       9'd100,
        center_x:          11'd960,
        center_y:          11'd540
    };

endpackage

// ===== sv/zdam_if.sv =====
// Zone dwell alarm monitor: valid/ready channel interfaces for requests and results.
// Depends on zdam_pkg for fixed field widths.
interface zdam_in_if #(
    parameter int TIME_BITS  = 48,
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [TIME_BITS-1:0]  time_ms;
    logic                  target_present;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;

    modport source (
        output valid, mode, time_ms, target_present, point_x, point_y,
        input  ready
    );
    modport sink (
        input  valid, mode, time_ms, target_present, point_x, point_y,
        output ready
    );
endinterface

interface zdam_out_if #(
    parameter int TIME_BITS = 48
);
    logic                             valid;
    logic                             ready;
    logic                             alarm_pulse;
    logic [zdam_pkg::STATE_BITS-1:0]  monitor_state;
    logic                             is_inside;
    logic                             short_loss;
    logic [zdam_pkg::DIST_BITS-1:0]   distance_sq;
    logic [TIME_BITS-1:0]             dwell_at_alarm_ms;
    logic                             reset_refused;

    modport source (
        output valid, alarm_pulse, monitor_state, is_inside, short_loss,
               distance_sq, dwell_at_alarm_ms, reset_refused,
        input  ready
    );
    modport sink (
        input  valid, alarm_pulse, monitor_state, is_inside, short_loss,
               distance_sq, dwell_at_alarm_ms, reset_refused,
        output ready
    );
endinterface

// ===== sv/zdam_queue.sv =====
// Zone dwell alarm monitor: small register queue between front and back.
// Generic width and depth; no package dependency.
module zdam_queue #(
    parameter int WIDTH = 76,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/zdam_front.sv =====
// Zone dwell alarm monitor: front end. Accepts requests, computes the squared
// distance to the circle center and the inside flag over two stages.
// Depends on zdam_pkg and zdam_in_if.
module zdam_front #(
    parameter int TIME_BITS  = 48,
    parameter int COORD_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    zdam_in_if.sink              item,
    input  zdam_pkg::cfg_t       cfg,
    output logic                 push_valid,
    input  logic                 push_ready,
    output logic [TIME_BITS+zdam_pkg::DIST_BITS+2:0] push_data
);

    localparam int AW  = (COORD_BITS > zdam_pkg::CENTER_BITS) ? COORD_BITS
                                                               : zdam_pkg::CENTER_BITS;
    localparam int DXW = AW + 1;
    localparam int SQW = 2 * AW;
    localparam int DW  = SQW + 1;
    localparam int RSW = 2 * zdam_pkg::RADIUS_BITS;
    localparam int DB  = zdam_pkg::DIST_BITS;

    logic                 en, take;
    logic [DXW-1:0]       dx, dy, ndx, ndy;
    logic [AW-1:0]        adx, ady;

    logic                 s1_valid_reg;
    logic                 s1_mode_reg, s1_present_reg;
    logic [TIME_BITS-1:0] s1_time_reg;
    logic [AW-1:0]        s1_adx_reg, s1_ady_reg;

    logic                 s2_valid_reg;
    logic                 s2_mode_reg, s2_present_reg;
    logic [TIME_BITS-1:0] s2_time_reg;
    logic [SQW-1:0]       s2_sqx_reg, s2_sqy_reg;
    logic [RSW-1:0]       s2_rsq_reg;

    logic [DW-1:0]        dist_sum;
    logic                 keep, in_zone;
    logic [DB-1:0]        dist_out;

    // whole front advances unless the last stage is blocked by a full queue
    assign en         = !s2_valid_reg || push_ready;
    assign item.ready = en;
    assign take       = item.valid && en;

    assign dx  = DXW'(item.point_x) - DXW'(cfg.center_x);
    assign dy  = DXW'(item.point_y) - DXW'(cfg.center_y);
    assign ndx = -dx;
    assign ndy = -dy;
    assign adx = dx[DXW-1] ? ndx[AW-1:0] : dx[AW-1:0];
    assign ady = dy[DXW-1] ? ndy[AW-1:0] : dy[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mode_reg    <= item.mode;
            s1_present_reg <= item.target_present;
            s1_time_reg    <= item.time_ms;
            s1_adx_reg     <= adx;
            s1_ady_reg     <= ady;

            s2_mode_reg    <= s1_mode_reg;
            s2_present_reg <= s1_present_reg;
            s2_time_reg    <= s1_time_reg;
            s2_sqx_reg     <= SQW'(s1_adx_reg) * SQW'(s1_adx_reg);
            s2_sqy_reg     <= SQW'(s1_ady_reg) * SQW'(s1_ady_reg);
            s2_rsq_reg     <= RSW'(cfg.zone_radius) * RSW'(cfg.zone_radius);
        end
    end

    // distance and inside flag only mean something for frames with a target
    assign dist_sum = DW'(s2_sqx_reg) + DW'(s2_sqy_reg);
    assign keep     = !s2_mode_reg && s2_present_reg;
    assign in_zone  = keep && (dist_sum <= DW'(s2_rsq_reg));
    assign dist_out = keep ? DB'(dist_sum) : '0;

    assign push_valid = s2_valid_reg;
    assign push_data  = {s2_mode_reg, s2_time_reg, s2_present_reg, in_zone, dist_out};

endmodule

// ===== sv/zdam_back.sv =====
// Zone dwell alarm monitor: back end. Runs the dwell/cooldown/loss state machine
// over one to four steps per request and holds the result register.
// Depends on zdam_pkg and zdam_out_if.
module zdam_back #(
    parameter int TIME_BITS = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  logic [TIME_BITS+zdam_pkg::DIST_BITS+2:0] head_data,
    output logic                 pop,
    input  zdam_pkg::cfg_t       cfg,
    zdam_out_if.source           result
);

    localparam int DB = zdam_pkg::DIST_BITS;
    localparam int SB = zdam_pkg::STATE_BITS;
    localparam int QW = TIME_BITS + DB + 3;

    // sequencer steps
    localparam logic [1:0] P_CONT  = 2'd0;  // continuity check, operator reset
    localparam logic [1:0] P_LOSS  = 2'd1;  // loss timer
    localparam logic [1:0] P_PAUSE = 2'd2;  // push running timer past a short loss
    localparam logic [1:0] P_EVAL  = 2'd3;  // inside/outside transitions

    logic                 h_mode, h_present, h_inside;
    logic [TIME_BITS-1:0] now;
    logic [DB-1:0]        h_dist;

    logic [1:0]           phase_reg, phase_next;
    logic [SB-1:0]        fsm_reg, fsm_next;
    logic                 latched_reg, latched_next;
    logic [TIME_BITS-1:0] exceed_start_reg, exceed_start_next;
    logic [TIME_BITS-1:0] cool_start_reg, cool_start_next;
    logic [TIME_BITS-1:0] lost_start_reg, lost_start_next;
    logic [TIME_BITS-1:0] prev_time_reg, prev_time_next;
    logic                 loss_active_reg, loss_active_next;
    logic                 seen_valid_reg, seen_valid_next;
    logic                 seen_inside_reg, seen_inside_next;
    logic                 pause_reg, pause_next;
    logic [TIME_BITS-1:0] lost_el_reg, lost_el_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_pulse_reg, out_pulse_next;
    logic [SB-1:0]        out_state_reg, out_state_next;
    logic                 out_inside_reg, out_inside_next;
    logic                 out_short_reg, out_short_next;
    logic [DB-1:0]        out_dist_reg, out_dist_next;
    logic [TIME_BITS-1:0] out_dwell_reg, out_dwell_next;
    logic                 out_refused_reg, out_refused_next;

    logic                 slot_free, emit;
    logic [TIME_BITS:0]   cont_diff;
    logic                 gap_break;
    logic [zdam_pkg::MS_BITS-1:0] tol;
    logic [TIME_BITS-1:0] lost_el, run_start, run_el, run_limit, pause_sum;
    logic                 lost_over, run_done, is_cool;

    assign h_mode    = head_data[QW-1];
    assign now       = head_data[QW-2 -: TIME_BITS];
    assign h_present = head_data[DB+1];
    assign h_inside  = head_data[DB];
    assign h_dist    = head_data[DB-1:0];

    assign slot_free = !out_valid_reg || result.ready;

    // a timestamp of zero in prev_time means no frame seen yet
    assign cont_diff = {1'b0, now} - {1'b0, prev_time_reg};
    assign gap_break = (prev_time_reg != '0)
                    && (cont_diff[TIME_BITS]
                        || (cont_diff[TIME_BITS-1:0] > TIME_BITS'(zdam_pkg::GAP_LIMIT_MS)));

    assign tol       = (cfg.loss_tolerance_ms == '0) ? zdam_pkg::DEFAULT_LOSS_MS
                                                     : cfg.loss_tolerance_ms;
    assign lost_el   = now - lost_start_reg;
    assign lost_over = (lost_el >= TIME_BITS'(tol));

    assign is_cool   = (fsm_reg == zdam_pkg::ST_COOLING);
    assign run_start = is_cool ? cool_start_reg : exceed_start_reg;
    assign run_el    = now - run_start;
    assign run_limit = is_cool ? TIME_BITS'(cfg.cooldown_ms) : TIME_BITS'(cfg.dwell_limit_ms);
    assign run_done  = (run_el >= run_limit);
    assign pause_sum = run_start + lost_el_reg;

    always_comb
    begin
        phase_next        = phase_reg;
        fsm_next          = fsm_reg;
        latched_next      = latched_reg;
        exceed_start_next = exceed_start_reg;
        cool_start_next   = cool_start_reg;
        lost_start_next   = lost_start_reg;
        prev_time_next    = prev_time_reg;
        loss_active_next  = loss_active_reg;
        seen_valid_next   = seen_valid_reg;
        seen_inside_next  = seen_inside_reg;
        pause_next        = pause_reg;
        lost_el_next      = lost_el_reg;

        pop              = 1'b0;
        emit             = 1'b0;
        out_pulse_next   = 1'b0;
        out_inside_next  = 1'b0;
        out_short_next   = 1'b0;
        out_dist_next    = '0;
        out_dwell_next   = '0;
        out_refused_next = 1'b0;

        case (phase_reg)
            P_CONT:
            begin
                if (head_valid)
                begin
                    if (h_mode)
                    begin
                        if (slot_free)
                        begin
                            pop  = 1'b1;
                            emit = 1'b1;
                            if (fsm_reg != zdam_pkg::ST_NORMAL
                                && (!seen_valid_reg || !seen_inside_reg))
                            begin
                                out_refused_next = 1'b1;
                            end
                            else
                            begin
                                fsm_next          = zdam_pkg::ST_NORMAL;
                                latched_next      = 1'b0;
                                exceed_start_next = '0;
                                cool_start_next   = '0;
                                lost_start_next   = '0;
                                loss_active_next  = 1'b0;
                                seen_inside_next  = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        prev_time_next = now;
                        phase_next     = P_LOSS;
                        if (gap_break)
                        begin
                            if (fsm_reg == zdam_pkg::ST_EXCEEDING)
                            begin
                                fsm_next     = zdam_pkg::ST_NORMAL;
                                latched_next = 1'b0;
                            end
                            else if (fsm_reg == zdam_pkg::ST_COOLING)
                            begin
                                fsm_next     = zdam_pkg::ST_ALARMED;
                                latched_next = 1'b1;
                            end
                            exceed_start_next = '0;
                            cool_start_next   = '0;
                            if (fsm_reg == zdam_pkg::ST_LOST)
                            begin
                                loss_active_next = 1'b1;
                                lost_start_next  = now;
                            end
                            else
                            begin
                                loss_active_next = 1'b0;
                                lost_start_next  = '0;
                            end
                        end
                    end
                end
            end

            P_LOSS:
            begin
                if (!h_present)
                begin
                    if (slot_free)
                    begin
                        pop             = 1'b1;
                        emit            = 1'b1;
                        phase_next      = P_CONT;
                        seen_valid_next = 1'b0;
                        if (!loss_active_reg)
                        begin
                            loss_active_next = 1'b1;
                            lost_start_next  = now;
                        end
                        else if (lost_over && fsm_reg != zdam_pkg::ST_LOST)
                        begin
                            if (fsm_reg == zdam_pkg::ST_ALARMED || is_cool)
                            begin
                                latched_next = 1'b1;
                            end
                            fsm_next          = zdam_pkg::ST_LOST;
                            exceed_start_next = '0;
                            cool_start_next   = '0;
                        end
                        out_short_next = !(fsm_reg == zdam_pkg::ST_LOST
                                           || (loss_active_reg && lost_over));
                    end
                end
                else
                begin
                    phase_next   = P_PAUSE;
                    lost_el_next = loss_active_reg ? lost_el : '0;
                    pause_next   = loss_active_reg && !lost_over;
                    if (loss_active_reg && lost_over && fsm_reg != zdam_pkg::ST_LOST)
                    begin
                        if (fsm_reg == zdam_pkg::ST_ALARMED || is_cool)
                        begin
                            latched_next = 1'b1;
                        end
                        fsm_next          = zdam_pkg::ST_LOST;
                        exceed_start_next = '0;
                        cool_start_next   = '0;
                    end
                end
            end

            P_PAUSE:
            begin
                phase_next = P_EVAL;
                if (pause_reg && fsm_reg == zdam_pkg::ST_EXCEEDING)
                begin
                    exceed_start_next = pause_sum;
                end
                else if (pause_reg && is_cool)
                begin
                    cool_start_next = pause_sum;
                end
            end

            P_EVAL:
            begin
                if (slot_free)
                begin
                    pop             = 1'b1;
                    emit            = 1'b1;
                    phase_next      = P_CONT;
                    out_inside_next = h_inside;
                    out_dist_next   = h_dist;
                    if (fsm_reg == zdam_pkg::ST_LOST)
                    begin
                        if (latched_reg)
                        begin
                            if (h_inside)
                            begin
                                fsm_next        = zdam_pkg::ST_COOLING;
                                cool_start_next = now;
                            end
                            else
                            begin
                                fsm_next = zdam_pkg::ST_ALARMED;
                            end
                        end
                        else if (h_inside)
                        begin
                            fsm_next = zdam_pkg::ST_NORMAL;
                        end
                        else
                        begin
                            fsm_next          = zdam_pkg::ST_EXCEEDING;
                            exceed_start_next = now;
                        end
                    end
                    else if (h_inside)
                    begin
                        if (fsm_reg == zdam_pkg::ST_EXCEEDING)
                        begin
                            fsm_next          = zdam_pkg::ST_NORMAL;
                            exceed_start_next = '0;
                        end
                        else if (fsm_reg == zdam_pkg::ST_ALARMED)
                        begin
                            fsm_next        = zdam_pkg::ST_COOLING;
                            cool_start_next = now;
                        end
                        else if (is_cool && run_done)
                        begin
                            fsm_next          = zdam_pkg::ST_NORMAL;
                            latched_next      = 1'b0;
                            exceed_start_next = '0;
                            cool_start_next   = '0;
                        end
                    end
                    else
                    begin
                        if (fsm_reg == zdam_pkg::ST_NORMAL)
                        begin
                            fsm_next          = zdam_pkg::ST_EXCEEDING;
                            exceed_start_next = now;
                        end
                        else if (fsm_reg == zdam_pkg::ST_EXCEEDING && run_done)
                        begin
                            fsm_next       = zdam_pkg::ST_ALARMED;
                            latched_next   = 1'b1;
                            out_pulse_next = 1'b1;
                            out_dwell_next = run_el;
                        end
                        else if (is_cool)
                        begin
                            fsm_next        = zdam_pkg::ST_ALARMED;
                            cool_start_next = '0;
                            latched_next    = 1'b1;
                        end
                    end
                    loss_active_next = 1'b0;
                    lost_start_next  = '0;
                    seen_valid_next  = 1'b1;
                    seen_inside_next = h_inside;
                end
            end

            default:
            begin
                phase_next = P_CONT;
            end
        endcase

        out_state_next = fsm_next;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !result.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= P_CONT;
            fsm_reg          <= zdam_pkg::ST_NORMAL;
            latched_reg      <= 1'b0;
            exceed_start_reg <= '0;
            cool_start_reg   <= '0;
            lost_start_reg   <= '0;
            prev_time_reg    <= '0;
            loss_active_reg  <= 1'b0;
            seen_valid_reg   <= 1'b0;
            seen_inside_reg  <= 1'b1;
            pause_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            fsm_reg          <= fsm_next;
            latched_reg      <= latched_next;
            exceed_start_reg <= exceed_start_next;
            cool_start_reg   <= cool_start_next;
            lost_start_reg   <= lost_start_next;
            prev_time_reg    <= prev_time_next;
            loss_active_reg  <= loss_active_next;
            seen_valid_reg   <= seen_valid_next;
            seen_inside_reg  <= seen_inside_next;
            pause_reg        <= pause_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lost_el_reg <= lost_el_next;
        if (emit)
        begin
            out_pulse_reg   <= out_pulse_next;
            out_state_reg   <= out_state_next;
            out_inside_reg  <= out_inside_next;
            out_short_reg   <= out_short_next;
            out_dist_reg    <= out_dist_next;
            out_dwell_reg   <= out_dwell_next;
            out_refused_reg <= out_refused_next;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.alarm_pulse       = out_pulse_reg;
    assign result.monitor_state     = out_state_reg;
    assign result.is_inside         = out_inside_reg;
    assign result.short_loss        = out_short_reg;
    assign result.distance_sq       = out_dist_reg;
    assign result.dwell_at_alarm_ms = out_dwell_reg;
    assign result.reset_refused     = out_refused_reg;

endmodule

// ===== sv/zone_dwell_alarm_monitor_unit.sv =====
// Zone dwell alarm monitor, top level: configuration registers, front end,
// request queue and state machine back end.
// Depends on zdam_pkg, zdam_if, zdam_front, zdam_queue, zdam_back.
//
// Usage:
//   item   : valid/ready request channel. mode 0 is a video frame (timestamp,
//            optional target point), mode 1 an operator reset request.
//   result : valid/ready channel, exactly one result per request, in order.
//   cfg_*  : write-only register port; write only while the block is idle.
// Throughput is set by the back-end sequencer: a frame with a target runs the
// continuity, loss, pause and evaluation steps, one without a target only the
// continuity and loss steps, and a reset request only the continuity step.
// The two-stage distance front end takes a request every cycle unless a full
// queue blocks its last stage, and a 4-entry queue absorbs bursts.
// A stalled result holds in the output register; the back end waits on it
// while the queue and the front end keep accepting until full.
// Reset clears the state machine to normal, empties the queue and loads
// the default register values; no clearing pass is needed.
module zone_dwell_alarm_monitor_unit #(
    parameter int TIME_BITS  = 48,
    parameter int COORD_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    zdam_in_if.sink                              item,
    zdam_out_if.source                           result,
    input  logic                                 cfg_we,
    input  logic [zdam_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [zdam_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

    localparam int QW = TIME_BITS + zdam_pkg::DIST_BITS + 3;

    zdam_pkg::cfg_t cfg_reg;

    logic          push_valid, push_ready;
    logic [QW-1:0] push_data;
    logic          head_valid, pop;
    logic [QW-1:0] head_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= zdam_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                zdam_pkg::REG_DWELL_LIMIT: cfg_reg.dwell_limit_ms    <= cfg_wdata;
                zdam_pkg::REG_COOLDOWN:    cfg_reg.cooldown_ms       <= cfg_wdata;
                zdam_pkg::REG_LOSS_TOL:    cfg_reg.loss_tolerance_ms <= cfg_wdata;
                zdam_pkg::REG_SAFE_RADIUS:
                    cfg_reg.zone_radius <= cfg_wdata[zdam_pkg::RADIUS_BITS-1:0];
                zdam_pkg::REG_CENTER_X:
                    cfg_reg.center_x <= cfg_wdata[zdam_pkg::CENTER_BITS-1:0];
                zdam_pkg::REG_CENTER_Y:
                    cfg_reg.center_y <= cfg_wdata[zdam_pkg::CENTER_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    zdam_front #(
        .TIME_BITS  (TIME_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    zdam_queue #(
        .WIDTH (QW),
        .DEPTH (zdam_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (head_valid),
        .pop_data   (head_data)
    );

    zdam_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .cfg        (cfg_reg),
        .result     (result)
    );

endmodule
